### hdl/sdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdt_pkg;
    localparam int LEN_W       = 7;
    localparam int SCALE_W     = 32;
    localparam int SQD_W       = 49;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_SCALE  = 2'd1;

    localparam logic [LEN_W-1:0]   LEN_RESET   = 7'd64;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd16777216;
    localparam logic [SQD_W-1:0]   SQD_MAX     = {SQD_W{1'b1}};
endpackage
`default_nettype wire

### hdl/sdt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/sdt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sdt_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    input  wire logic             i_pop
);
    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

### hdl/sdt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sdt_front #(
    parameter int MAX_LENGTH = 64,
    parameter int COST_BITS  = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [COST_BITS-1:0]               i_cost,
    input  wire logic [sdt_pkg::LEN_W-1:0]          i_length,
    input  wire logic                               i_clear,
    output logic                                    o_push,
    output logic [COST_BITS+$clog2(MAX_LENGTH):0]   o_item,
    input  wire logic                               i_queue_ready
);
    import sdt_pkg::*;

    localparam int IW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int EW = (CW > LEN_W) ? CW : LEN_W;

    logic [CW-1:0] r_cnt;
    logic [EW-1:0] w_len_e;
    logic [EW-1:0] w_n_e;
    logic [CW-1:0] w_n;
    logic [IW-1:0] w_q;
    logic [CW-1:0] w_q_next;
    logic          w_last;

    assign w_len_e  = EW'(i_length);
    assign w_n_e    = (w_len_e == '0) ? EW'(1) :
                      (w_len_e > EW'(MAX_LENGTH)) ? EW'(MAX_LENGTH) : w_len_e;
    assign w_n      = CW'(w_n_e);
    assign w_q      = (r_cnt >= w_n) ? '0 : r_cnt[IW-1:0];
    assign w_q_next = CW'(w_q) + CW'(1);
    assign w_last   = (w_q_next == w_n);

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;
    assign o_item  = {w_last, w_q, i_cost};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_clear) begin
            r_cnt <= '0;
        end else if (o_push) begin
            r_cnt <= w_last ? '0 : w_q_next;
        end
    end
endmodule
`default_nettype wire

### hdl/sdt_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sdt_back #(
    parameter int MAX_LENGTH = 64,
    parameter int COST_BITS  = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [COST_BITS+$clog2(MAX_LENGTH):0] i_item,
    input  wire logic [sdt_pkg::SCALE_W-1:0]        i_scale,
    output logic                                    o_valid,
    input  wire logic                               i_out_ready,
    output logic [sdt_pkg::SQD_W-1:0]               o_sq,
    output logic                                    o_last
);
    import sdt_pkg::*;

    localparam int IW   = $clog2(MAX_LENGTH);
    localparam int FW   = ((COST_BITS > 2 * IW) ? COST_BITS : 2 * IW) + 1;
    localparam int NW   = FW + 1;
    localparam int DW   = IW + 1;
    localparam int PRW  = NW + DW + 1;
    localparam int PW   = FW + SCALE_W;
    localparam int SHW  = PW - 8;
    localparam int CMPW = (SHW > SQD_W) ? SHW : SQD_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ISSUE    = 4'd1;
    localparam logic [3:0] S_RV       = 4'd2;
    localparam logic [3:0] S_RF       = 4'd3;
    localparam logic [3:0] S_MUL      = 4'd4;
    localparam logic [3:0] S_CMP      = 4'd5;
    localparam logic [3:0] S_SW_ISSUE = 4'd6;
    localparam logic [3:0] S_SW_CHK   = 4'd7;
    localparam logic [3:0] S_SW_F     = 4'd8;
    localparam logic [3:0] S_SW_MUL   = 4'd9;
    localparam logic [3:0] S_SW_OUT   = 4'd10;

    logic [3:0]            r_state;
    logic [IW-1:0]         r_top;
    logic [IW-1:0]         r_k;
    logic [IW-1:0]         r_q;
    logic [IW-1:0]         r_sq;
    logic [IW-1:0]         r_v;
    logic                  r_last;
    logic [FW-1:0]         r_fq;
    logic signed [NW-1:0]  r_num;
    logic [DW-1:0]         r_den;
    logic signed [NW-1:0]  r_ntop;
    logic [DW-1:0]         r_dtop;
    logic signed [PRW-1:0] r_p1;
    logic signed [PRW-1:0] r_p2;
    logic [FW-1:0]         r_d;
    logic [PW-1:0]         r_prod;
    logic                  r_ovalid;
    logic [SQD_W-1:0]      r_osq;
    logic                  r_olast;

    logic [COST_BITS-1:0]  w_cost;
    logic [IW-1:0]         w_iq;
    logic                  w_ilast;
    logic                  w_take;

    logic                  w_smp_we;
    logic [COST_BITS-1:0]  w_smp_rd;
    logic                  w_vtx_we;
    logic [IW-1:0]         w_vtx_wa;
    logic [IW-1:0]         w_vtx_wd;
    logic [IW-1:0]         w_vtx_ra;
    logic [IW-1:0]         w_vtx_rd;
    logic                  w_env_we;
    logic [IW-1:0]         w_env_wa;
    logic [IW-1:0]         w_env_ra;
    logic [NW-1:0]         w_num_rd;
    logic [DW-1:0]         w_den_rd;

    logic [FW-1:0]         w_fv;
    logic signed [NW-1:0]  w_num_new;
    logic [IW-1:0]         w_diff;
    logic                  w_pop;
    logic [NW-1:0]         w_qd;
    logic                  w_adv;
    logic [IW-1:0]         w_ad;
    logic [SHW-1:0]        w_shift;
    logic                  w_sat;
    logic                  w_oslot;

    assign {w_ilast, w_iq, w_cost} = i_item;
    assign o_ready = (r_state == S_IDLE);
    assign w_take  = i_valid && o_ready;

    assign w_smp_we = w_take;
    assign w_vtx_we = (w_take && (w_iq == '0)) || (r_state == S_CMP && !w_pop);
    assign w_vtx_wa = (r_state == S_CMP) ? r_top + IW'(1) : '0;
    assign w_vtx_wd = (r_state == S_CMP) ? r_q : '0;
    assign w_vtx_ra = (r_state == S_SW_ISSUE) ? r_k : r_top;
    assign w_env_we = (r_state == S_CMP) && !w_pop;
    assign w_env_wa = r_top + IW'(1);
    assign w_env_ra = (r_state == S_SW_ISSUE) ? r_k + IW'(1) : r_top;

    sdt_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_LENGTH)) u_smp (
        .i_clk(i_clk), .i_we(w_smp_we), .i_waddr(w_iq), .i_wdata(w_cost),
        .i_raddr(w_vtx_rd), .o_rdata(w_smp_rd)
    );
    sdt_ram #(.WIDTH(IW), .DEPTH(MAX_LENGTH)) u_vtx (
        .i_clk(i_clk), .i_we(w_vtx_we), .i_waddr(w_vtx_wa), .i_wdata(w_vtx_wd),
        .i_raddr(w_vtx_ra), .o_rdata(w_vtx_rd)
    );
    sdt_ram #(.WIDTH(NW), .DEPTH(MAX_LENGTH)) u_num (
        .i_clk(i_clk), .i_we(w_env_we), .i_waddr(w_env_wa), .i_wdata(r_num),
        .i_raddr(w_env_ra), .o_rdata(w_num_rd)
    );
    sdt_ram #(.WIDTH(DW), .DEPTH(MAX_LENGTH)) u_den (
        .i_clk(i_clk), .i_we(w_env_we), .i_waddr(w_env_wa), .i_wdata(r_den),
        .i_raddr(w_env_ra), .o_rdata(w_den_rd)
    );

    // crossing of the new sample against the current top vertex
    assign w_fv      = FW'(w_smp_rd) + FW'(r_v) * FW'(r_v);
    assign w_num_new = $signed({1'b0, r_fq}) - $signed({1'b0, w_fv});
    assign w_diff    = r_q - r_v;
    assign w_pop     = (r_top != '0) && (r_p1 <= r_p2);

    assign w_qd  = NW'(r_sq) * NW'(w_den_rd);
    assign w_adv = (r_k != r_top) && ($signed(w_num_rd) < $signed(w_qd));
    assign w_ad  = (r_sq >= r_v) ? r_sq - r_v : r_v - r_sq;

    assign w_shift = r_prod[PW-1:8];
    assign w_sat   = CMPW'(w_shift) > CMPW'(SQD_MAX);
    assign w_oslot = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && (r_state != S_SW_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_q    <= w_iq;
                        r_last <= w_ilast;
                        r_fq   <= FW'(w_cost) + FW'(w_iq) * FW'(w_iq);
                        if (w_iq == '0) begin
                            r_top <= '0;
                            if (w_ilast) begin
                                r_k     <= '0;
                                r_sq    <= '0;
                                r_state <= S_SW_ISSUE;
                            end
                        end else begin
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: r_state <= S_RV;
                S_RV: begin
                    r_v     <= w_vtx_rd;
                    r_state <= S_RF;
                end
                S_RF: begin
                    r_num   <= w_num_new;
                    r_den   <= {w_diff, 1'b0};
                    r_ntop  <= $signed(w_num_rd);
                    r_dtop  <= w_den_rd;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p1    <= PRW'(r_num) * PRW'($signed({1'b0, r_dtop}));
                    r_p2    <= PRW'(r_ntop) * PRW'($signed({1'b0, r_den}));
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_pop) begin
                        r_top   <= r_top - IW'(1);
                        r_state <= S_ISSUE;
                    end else begin
                        r_top <= r_top + IW'(1);
                        if (r_last) begin
                            r_k     <= '0;
                            r_sq    <= '0;
                            r_state <= S_SW_ISSUE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SW_ISSUE: r_state <= S_SW_CHK;
                S_SW_CHK: begin
                    if (w_adv) begin
                        r_k     <= r_k + IW'(1);
                        r_state <= S_SW_ISSUE;
                    end else begin
                        r_v     <= w_vtx_rd;
                        r_state <= S_SW_F;
                    end
                end
                S_SW_F: begin
                    r_d     <= FW'(w_ad) * FW'(w_ad) + FW'(w_smp_rd);
                    r_state <= S_SW_MUL;
                end
                S_SW_MUL: begin
                    r_prod  <= PW'(r_d) * PW'(i_scale);
                    r_state <= S_SW_OUT;
                end
                S_SW_OUT: begin
                    if (w_oslot) begin
                        r_ovalid <= 1'b1;
                        r_osq    <= w_sat ? SQD_MAX : SQD_W'(w_shift);
                        r_olast  <= (r_sq == r_q);
                        if (r_sq == r_q) begin
                            r_top   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_sq    <= r_sq + IW'(1);
                            r_state <= S_SW_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_sq    = r_osq;
    assign o_last  = r_olast;

    a_top_le_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_top <= r_q))
        else $error("envelope top beyond current sample");
    a_k_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_CHK) |-> (r_k <= r_top))
        else $error("sweep vertex beyond envelope top");
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_OUT && r_ovalid && !i_out_ready) |=> (r_state == S_SW_OUT))
        else $error("sweep advanced over a held result");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_OUT) |-> !o_ready)
        else $error("item taken during sweep");
endmodule
`default_nettype wire

### hdl/squared_distance_transform_line.sv
`timescale 1ns / 1ps
`default_nettype none
// Squared distance transform of one line of costs. Each cost beat is placed in
// a two-entry queue and merged into a lower envelope of parabolas held in
// block RAM: it reads the top vertex, forms its crossing with it and
// cross-multiplies against the top's crossing, removing the top vertex while
// the compare says so (the first beat of a line starts a new envelope). The
// line's last beat starts the sweep, which delivers one result per position:
// it passes the envelope vertices whose crossing lies before the position,
// reads the sample and applies the scale multiply, waiting while the output
// is held off. No new cost beat enters the envelope during a sweep. Results
// carry 16 fraction bits and saturate at 2^49-1.
module squared_distance_transform_line #(
    parameter int MAX_LENGTH = 64,
    parameter int COST_BITS  = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [((COST_BITS+7)/8)*8-1:0]     s_axis_tdata,  // cost
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [sdt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // sq_distance
    output logic                                    m_axis_tlast,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire sdt_pkg::t_cfg_idx                  i_cfg_index,
    input  wire logic [sdt_pkg::SCALE_W-1:0]        i_cfg_data
);
    import sdt_pkg::*;

    localparam int IW    = $clog2(MAX_LENGTH);
    localparam int ITW   = COST_BITS + IW + 1;
    localparam int INPAD = ((COST_BITS + 7) / 8) * 8;

    logic [LEN_W-1:0]   r_length;
    logic [SCALE_W-1:0] r_scale;
    logic               w_cfg_wr;
    logic               w_len_wr;
    logic               w_push;
    logic [ITW-1:0]     w_item_in;
    logic               w_q_ready;
    logic               w_q_valid;
    logic [ITW-1:0]     w_item_out;
    logic               w_pop;
    logic [SQD_W-1:0]   w_sq;
    logic [INPAD-1:0]   w_in_unused;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign w_len_wr    = w_cfg_wr && (i_cfg_index == CFG_LENGTH);
    assign w_in_unused = s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LEN_RESET;
            r_scale  <= SCALE_RESET;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_LENGTH: r_length <= i_cfg_data[LEN_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sdt_front #(.MAX_LENGTH(MAX_LENGTH), .COST_BITS(COST_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cost(w_in_unused[COST_BITS-1:0]),
        .i_length(r_length), .i_clear(w_len_wr),
        .o_push(w_push), .o_item(w_item_in), .i_queue_ready(w_q_ready)
    );

    sdt_queue #(.WIDTH(ITW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_item_in), .o_ready(w_q_ready),
        .o_valid(w_q_valid), .o_data(w_item_out), .i_pop(w_pop)
    );

    sdt_back #(.MAX_LENGTH(MAX_LENGTH), .COST_BITS(COST_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_pop), .i_item(w_item_out),
        .i_scale(r_scale),
        .o_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_sq(w_sq), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - SQD_W){1'b0}}, w_sq};
endmodule
`default_nettype wire

### verif/squared_distance_transform_line_tb.sv
`timescale 1ns / 1ps
module squared_distance_transform_line_tb;
    import sdt_pkg::*;

    localparam int MAXN   = 64;
    localparam int SETTLE = 400;

    typedef struct {
        logic [SQD_W-1:0] sqd;
        logic             last;
    } t_dist_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index = CFG_LENGTH;
    logic [SCALE_W-1:0]   i_cfg_data = '0;

    squared_distance_transform_line DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // envelope predictor state
    logic [LEN_W-1:0]   line_len_reg;
    logic [SCALE_W-1:0] scale_reg;
    longint             line_cost [MAXN];
    int                 env_vertex [MAXN];
    longint             env_num [MAXN+1];
    longint             env_den [MAXN+1];
    int                 env_top;
    int                 loaded;

    t_dist_beat         pending_dist[$];
    int                 errors = 0;
    bit                 no_gaps = 1'b0;
    int                 hold_cycles = 0;

    function automatic int line_len();
        if (line_len_reg == 0) return 1;
        if (line_len_reg > MAXN) return MAXN;
        return line_len_reg;
    endfunction

    function automatic logic [SQD_W-1:0] scaled(longint unsigned d);
        longint unsigned hi, lo, r, sat;
        sat = (64'd1 << 49) - 1;
        hi = (d >> 16) * longint'(scale_reg);
        lo = (d & 64'hFFFF) * longint'(scale_reg);
        if (hi > (sat >> 8)) return sat[SQD_W-1:0];
        r = (hi << 8) + (lo >> 8);
        if (r > sat) return sat[SQD_W-1:0];
        return r[SQD_W-1:0];
    endfunction

    task automatic merge_cost(input logic [23:0] c);
        int n, q, v, k;
        longint fq, num, den, dq;
        t_dist_beat b;
        n = line_len();
        if (loaded >= n) loaded = 0;
        q = loaded;
        line_cost[q] = c;
        if (q == 0) begin
            env_top = 0;
            env_vertex[0] = 0;
        end else begin
            fq = line_cost[q] + q * q;
            forever begin
                v = env_vertex[env_top];
                num = fq - (line_cost[v] + v * v);
                den = 2 * (q - v);
                if (env_top == 0) break;
                if (num * env_den[env_top] <= env_num[env_top] * den) env_top--;
                else break;
            end
            env_top++;
            env_vertex[env_top] = q;
            env_num[env_top] = num;
            env_den[env_top] = den;
        end
        loaded = q + 1;
        if (loaded < n) return;
        k = 0;
        for (q = 0; q < n; q++) begin
            while (k < env_top && env_num[k+1] < q * env_den[k+1]) k++;
            v = env_vertex[k];
            dq = q - v;
            b.sqd = scaled(dq * dq + line_cost[v]);
            b.last = (q + 1 == n);
            pending_dist.push_back(b);
        end
        loaded = 0;
        env_top = 0;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_cost(input logic [23:0] c);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        merge_cost(c);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_dist.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [SCALE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LENGTH) begin
            line_len_reg = val[LEN_W-1:0];
            loaded = 0;
            env_top = 0;
        end else begin
            scale_reg = val;
        end
    endtask

    // receiver: random stalls, plus forced long hold-off
    always @(posedge i_clk) begin
        int stall;
        t_dist_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_dist.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, 0);
            end else begin
                want = pending_dist.pop_front();
                if (m_axis_tdata[SQD_W-1:0] !== want.sqd)
                    report_mismatch("sq_distance", m_axis_tdata[SQD_W-1:0], want.sqd);
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", m_axis_tlast, want.last);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            stall = pick_gap();
            m_axis_tready <= (stall == 0);
        end
    end

    task automatic send_line(input int n, input int mode);
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: send_cost(24'($urandom_range(0, 60)));
                1: send_cost(24'($urandom()));
                default: send_cost(($urandom_range(0, 3) == 0) ? 24'hFFFFFF
                                                                 : 24'($urandom_range(0, 4000)));
            endcase
        end
    endtask

    task automatic test_directed();
        write_reg(CFG_LENGTH, 1);
        write_reg(CFG_SCALE, 32'hFFFF_FFFF);
        send_cost(24'h000000);
        send_cost(24'hFFFFFF);
        drain();
        write_reg(CFG_LENGTH, 0);
        send_cost(24'h555555);
        send_cost(24'hAAAAAA);
        drain();
        write_reg(CFG_LENGTH, 5);
        write_reg(CFG_SCALE, 0);
        send_cost(24'd0); send_cost(24'hFFFFFF); send_cost(24'd0); send_cost(24'hFFFFFF);
        send_cost(24'd0);
        drain();
        write_reg(CFG_SCALE, SCALE_RESET);
        send_cost(24'd9); send_cost(24'd4); send_cost(24'd1); send_cost(24'd0);
        send_cost(24'd1);
        // partial line dropped by a length write
        send_cost(24'd7); send_cost(24'd3);
        stop_sending();
        drain();
        write_reg(CFG_LENGTH, 3);
        send_cost(24'hFFFFFF); send_cost(24'd2); send_cost(24'hFFFFFF);
        drain();
    endtask

    task automatic test_full_lines();
        write_reg(CFG_LENGTH, 127);
        write_reg(CFG_SCALE, 32'h0300_0000);
        send_line(64, 2);
        drain();
    endtask

    task automatic test_random_lines();
        int sent, n, r, reps, part;
        sent = 0;
        while (sent < 64) begin
            r = $urandom_range(0, 9);
            n = (r == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            write_reg(CFG_LENGTH, n);
            r = $urandom_range(0, 5);
            write_reg(CFG_SCALE, (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'h0 : $urandom());
            no_gaps = ($urandom_range(0, 3) == 0);
            reps = $urandom_range(1, 2);
            send_line(n * reps, $urandom_range(0, 2));
            sent += n * reps;
            if ($urandom_range(0, 4) == 0) begin
                part = $urandom_range(1, n);
                send_line(part, 1);
                sent += part;
                stop_sending();
            end
            drain();
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(CFG_LENGTH, 6);
        write_reg(CFG_SCALE, SCALE_RESET);
        hold_cycles = 300;
        send_line(24, 0);
        stop_sending();
        drain();
    endtask

    initial begin
        line_len_reg = LEN_RESET;
        scale_reg = SCALE_RESET;
        loaded = 0;
        env_top = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_lines();
        test_full_lines();
        if (errors == 0 && pending_dist.size() == 0) begin
            $display("squared_distance_transform_line_tb: clean");
        end else begin
            $display("squared_distance_transform_line_tb: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("squared_distance_transform_line_tb: errors");
        $finish;
    end
endmodule

### files.f
hdl/sdt_pkg.sv
hdl/sdt_ram.sv
hdl/sdt_queue.sv
hdl/sdt_front.sv
hdl/sdt_back.sv
hdl/squared_distance_transform_line.sv
verif/squared_distance_transform_line_tb.sv
